>>> hdl/tnp_pkg.sv
// Shared types and constants for the triangle normal / point-inside block.
package tnp_pkg;

  localparam int THRESH_BITS = 63;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 63'd281475;

  localparam int MAG_BITS  = 31;
  localparam int SUM_BITS  = 64;
  localparam int ROOT_BITS = 32;
  localparam int QUO_BITS  = 31;
  localparam int NORM_BITS = 32;
  localparam int FRAC_OUT  = 30;

  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [2:0]               neg;
    logic                     degen;
    logic                     in_tri;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hdl/triangle_normal_point_inside_core.sv
// Top level of the triangle unit normal and point-in-triangle block.
// Input channel: in_valid / in_stall carry one word of three vertices and a
// query point, signed fixed point, COORD_BITS each. Output channel:
// out_valid / out_stall carry the Q2.30 unit normal, is_degenerate and
// point_inside. cfg_write loads cfg_data into the degenerate threshold.
// One word is taken per cycle and one result leaves per cycle when the
// receiver does not stall. The pipeline has 9 front stages (cross
// products, wide multipliers, compares, shift), the word queue, then the
// back stages that hold the 32-step square root and the 31-step restoring
// divider, and last the output register.
// A stalled output holds the whole back pipeline; the 4-word queue keeps
// the front running until it fills, then in_stall rises.
// Reset clears all valid flags and the queue and loads the threshold with
// its default; no results are pending after reset.
module triangle_normal_point_inside_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         vertex_a_x,
  input  logic signed [COORD_BITS-1:0]         vertex_a_y,
  input  logic signed [COORD_BITS-1:0]         vertex_a_z,
  input  logic signed [COORD_BITS-1:0]         vertex_b_x,
  input  logic signed [COORD_BITS-1:0]         vertex_b_y,
  input  logic signed [COORD_BITS-1:0]         vertex_b_z,
  input  logic signed [COORD_BITS-1:0]         vertex_c_x,
  input  logic signed [COORD_BITS-1:0]         vertex_c_y,
  input  logic signed [COORD_BITS-1:0]         vertex_c_z,
  input  logic signed [COORD_BITS-1:0]         query_x,
  input  logic signed [COORD_BITS-1:0]         query_y,
  input  logic signed [COORD_BITS-1:0]         query_z,
  input  logic                                 cfg_write,
  input  logic [tnp_pkg::THRESH_BITS-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_x,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_y,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_z,
  output logic                                 is_degenerate,
  output logic                                 point_inside
);

  logic [tnp_pkg::THRESH_BITS-1:0] threshold;
  logic                            front_en;
  logic                            front_valid;
  tnp_pkg::entry_t                 front_entry;
  tnp_pkg::entry_t                 queue_head;
  tnp_pkg::fifo_stat_t             queue_stat;
  logic                            pop;

  assign front_en = !queue_stat.full;
  assign in_stall = queue_stat.full;

  always_ff @(posedge clk) begin
    if (rst) threshold <= tnp_pkg::THRESH_RESET;
    else if (cfg_write) threshold <= cfg_data;
  end

  tnp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (front_en),
    .in_valid   (in_valid),
    .vertex_a_x (vertex_a_x),
    .vertex_a_y (vertex_a_y),
    .vertex_a_z (vertex_a_z),
    .vertex_b_x (vertex_b_x),
    .vertex_b_y (vertex_b_y),
    .vertex_b_z (vertex_b_z),
    .vertex_c_x (vertex_c_x),
    .vertex_c_y (vertex_c_y),
    .vertex_c_z (vertex_c_z),
    .query_x    (query_x),
    .query_y    (query_y),
    .query_z    (query_z),
    .threshold  (threshold),
    .out_valid  (front_valid),
    .out_entry  (front_entry)
  );

  tnp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_en && front_valid),
    .pop   (pop),
    .wdata (front_entry),
    .rdata (queue_head),
    .stat  (queue_stat)
  );

  tnp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (!queue_stat.empty),
    .entry         (queue_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .is_degenerate (is_degenerate),
    .point_inside  (point_inside)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_degenerate |->
      normal_x == 0 && normal_y == 0 && normal_z == 0 && point_inside)
    else $error("degenerate result with nonzero normal or outside point");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824 &&
      normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824 &&
      normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
    else $error("normal component beyond unit range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_stat.empty)
    else $error("queue read while empty");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !queue_stat.full)
    else $error("output or queue not cleared by reset");

endmodule

>>> hdl/tnp_wmul.sv
// Three-stage signed multiplier built from four half-width partial products.
module tnp_wmul #(
  parameter int W = 51
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic [W-1:0]     ma;
  logic [W-1:0]     mb;
  logic [2*H-1:0]   pp00;
  logic [H+L-1:0]   pp01;
  logic [H+L-1:0]   pp10;
  logic [2*L-1:0]   pp11;
  logic             sgn1;
  logic [2*W-1:0]   sum2;
  logic             sgn2;

  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= ma[H-1:0] * mb[H-1:0];
      pp01 <= ma[H-1:0] * mb[W-1:H];
      pp10 <= ma[W-1:H] * mb[H-1:0];
      pp11 <= ma[W-1:H] * mb[W-1:H];
      sgn1 <= a[W-1] ^ b[W-1];
      sum2 <= (2*W)'(pp00) + ((2*W)'(pp01) << H) + ((2*W)'(pp10) << H)
              + ((2*W)'(pp11) << (2*H));
      sgn2 <= sgn1;
      p    <= sgn2 ? $signed(~sum2 + 1'b1) : $signed(sum2);
    end
  end

endmodule

>>> hdl/tnp_front.sv
// Front end: edge vectors, cross products, degenerate test, edge signs, normalizing shift.
module tnp_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [COORD_BITS-1:0]      vertex_a_x,
  input  logic signed [COORD_BITS-1:0]      vertex_a_y,
  input  logic signed [COORD_BITS-1:0]      vertex_a_z,
  input  logic signed [COORD_BITS-1:0]      vertex_b_x,
  input  logic signed [COORD_BITS-1:0]      vertex_b_y,
  input  logic signed [COORD_BITS-1:0]      vertex_b_z,
  input  logic signed [COORD_BITS-1:0]      vertex_c_x,
  input  logic signed [COORD_BITS-1:0]      vertex_c_y,
  input  logic signed [COORD_BITS-1:0]      vertex_c_z,
  input  logic signed [COORD_BITS-1:0]      query_x,
  input  logic signed [COORD_BITS-1:0]      query_y,
  input  logic signed [COORD_BITS-1:0]      query_z,
  input  logic [tnp_pkg::THRESH_BITS-1:0]   threshold,
  output logic                              out_valid,
  output tnp_pkg::entry_t                   out_entry
);

  localparam int D  = COORD_BITS + 1;
  localparam int P  = 2 * D;
  localparam int NW = P + 1;
  localparam int AW = 2 * NW + 2;
  localparam int SW = (AW > 64) ? AW : 64;
  localparam int LW = $clog2(NW + 1);
  localparam int XW = NW + tnp_pkg::MAG_BITS;

  logic signed [D-1:0] pa [3];
  logic signed [D-1:0] pb [3];
  logic signed [D-1:0] pc [3];
  logic signed [D-1:0] pq [3];

  logic signed [D-1:0]    u1 [4][3];
  logic signed [D-1:0]    w1 [4][3];
  logic signed [P-1:0]    pr [4][6];
  logic signed [NW-1:0]   x3 [4][3];
  logic signed [2*NW-1:0] pw [4][3];

  logic [NW-1:0] mag4 [3];
  logic [NW-1:0] mag5 [3];
  logic [NW-1:0] mag6 [3];
  logic [NW-1:0] mag7 [3];
  logic [NW-1:0] mag8 [3];
  logic [2:0]    neg4, neg5, neg6, neg7, neg8;

  logic signed [AW-1:0] s7;
  logic signed [AW-1:0] acc7 [3];
  logic [NW-1:0]        big7;
  logic [NW-1:0]        big_c;
  logic                 degen8;
  logic                 inside8;
  logic [LW-1:0]        len8;
  logic [LW-1:0]        len_c;
  logic [2:0]           eneg_c, epos_c;
  logic [tnp_pkg::MAG_BITS-1:0] shm_c [3];

  logic v1, v2, v3, v4, v5, v6, v7, v8;

  always_comb begin
    pa[0] = D'(vertex_a_x); pa[1] = D'(vertex_a_y); pa[2] = D'(vertex_a_z);
    pb[0] = D'(vertex_b_x); pb[1] = D'(vertex_b_y); pb[2] = D'(vertex_b_z);
    pc[0] = D'(vertex_c_x); pc[1] = D'(vertex_c_y); pc[2] = D'(vertex_c_z);
    pq[0] = D'(query_x);    pq[1] = D'(query_y);    pq[2] = D'(query_z);
  end

  always_comb begin
    big_c = mag6[0];
    if (mag6[1] > big_c) big_c = mag6[1];
    if (mag6[2] > big_c) big_c = mag6[2];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eneg_c[k] = acc7[k][AW-1];
      epos_c[k] = !acc7[k][AW-1] && (acc7[k] != '0);
    end
  end

  always_comb begin
    len_c = '0;
    for (int b = 0; b < NW; b++) begin
      if (big7[b]) len_c = LW'(b + 1);
    end
  end

  always_comb begin
    logic [XW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = XW'(mag8[i]);
      if (int'(len8) > tnp_pkg::MAG_BITS) t = t >> (int'(len8) - tnp_pkg::MAG_BITS);
      else t = t << (tnp_pkg::MAG_BITS - int'(len8));
      shm_c[i] = t[tnp_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u1[0][i] <= pb[i] - pa[i];  w1[0][i] <= pc[i] - pa[i];
        u1[1][i] <= pq[i] - pa[i];  w1[1][i] <= pb[i] - pa[i];
        u1[2][i] <= pq[i] - pb[i];  w1[2][i] <= pc[i] - pb[i];
        u1[3][i] <= pq[i] - pc[i];  w1[3][i] <= pa[i] - pc[i];
      end
      for (int k = 0; k < 4; k++) begin
        pr[k][0] <= u1[k][1] * w1[k][2];
        pr[k][1] <= u1[k][2] * w1[k][1];
        pr[k][2] <= u1[k][2] * w1[k][0];
        pr[k][3] <= u1[k][0] * w1[k][2];
        pr[k][4] <= u1[k][0] * w1[k][1];
        pr[k][5] <= u1[k][1] * w1[k][0];
        for (int i = 0; i < 3; i++) begin
          x3[k][i] <= NW'(pr[k][2*i]) - NW'(pr[k][2*i+1]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        mag4[i] <= x3[0][i][NW-1] ? (~x3[0][i] + 1'b1) : x3[0][i];
        neg4[i] <= x3[0][i][NW-1];
        mag5[i] <= mag4[i];
        mag6[i] <= mag5[i];
        mag7[i] <= mag6[i];
        mag8[i] <= mag7[i];
      end
      neg5 <= neg4;
      neg6 <= neg5;
      neg7 <= neg6;
      neg8 <= neg7;
      s7   <= AW'(pw[0][0]) + AW'(pw[0][1]) + AW'(pw[0][2]);
      for (int k = 0; k < 3; k++) begin
        acc7[k] <= AW'(pw[k+1][0]) + AW'(pw[k+1][1]) + AW'(pw[k+1][2]);
      end
      big7    <= big_c;
      degen8  <= !(SW'($unsigned(s7)) > SW'(threshold));
      inside8 <= !(SW'($unsigned(s7)) > SW'(threshold)) || !((|eneg_c) && (|epos_c));
      len8    <= len_c;
      for (int i = 0; i < 3; i++) out_entry.mag[i] <= shm_c[i];
      out_entry.neg    <= neg8;
      out_entry.degen  <= degen8;
      out_entry.in_tri <= inside8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; out_valid <= v8;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_edge
    for (genvar i = 0; i < 3; i++) begin : g_axis
      tnp_wmul #(.W(NW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (x3[k][i]),
        .b   (x3[0][i]),
        .p   (pw[k][i])
      );
    end
  end

endmodule

>>> hdl/tnp_fifo.sv
// Short word queue between the front end and the back end.
module tnp_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                pop,
  input  tnp_pkg::entry_t     wdata,
  output tnp_pkg::entry_t     rdata,
  output tnp_pkg::fifo_stat_t stat
);

  localparam int DEPTH = 4;
  localparam int AB    = $clog2(DEPTH);

  tnp_pkg::entry_t mem [DEPTH];
  logic [AB-1:0]   wr_ptr;
  logic [AB-1:0]   rd_ptr;
  logic [AB:0]     count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == (AB+1)'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AB+1)'(push) - (AB+1)'(pop);
    end
  end

endmodule

>>> hdl/tnp_back.sv
// Back end: square root and division pipelines, sign restore, output register.
module tnp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                avail,
  input  tnp_pkg::entry_t                     entry,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_x,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_y,
  output logic signed [tnp_pkg::NORM_BITS-1:0] normal_z,
  output logic                                is_degenerate,
  output logic                                point_inside
);

  localparam int SB = tnp_pkg::SUM_BITS;
  localparam int RB = tnp_pkg::ROOT_BITS;
  localparam int QB = tnp_pkg::QUO_BITS;
  localparam int NB = tnp_pkg::NORM_BITS;

  logic en;
  logic va;
  tnp_pkg::entry_t ea;
  logic [2*tnp_pkg::MAG_BITS-1:0] sqm [3];

  logic            sv   [RB+1];
  tnp_pkg::entry_t se   [RB+1];
  logic [SB-1:0]   srem [RB+1];
  logic [RB-1:0]   sres [RB+1];

  logic            dv    [QB+1];
  tnp_pkg::entry_t de    [QB+1];
  logic [RB-1:0]   droot [QB+1];
  logic [SB-1:0]   drem  [QB+1][3];
  logic [QB-1:0]   dq    [QB+1][3];

  logic [NB-1:0]   nrm [3];

  assign en  = !out_valid || !out_stall;
  assign pop = en && avail;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqm[i] = ea.mag[i] * ea.mag[i];
      if (de[QB].degen) nrm[i] = '0;
      else if (de[QB].neg[i]) nrm[i] = NB'(0) - NB'(dq[QB][i]);
      else nrm[i] = NB'(dq[QB][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; sv[0] <= 1'b0; dv[0] <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      va <= avail; sv[0] <= va; dv[0] <= sv[RB]; out_valid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea      <= entry;
      se[0]   <= ea;
      srem[0] <= SB'(sqm[0]) + SB'(sqm[1]) + SB'(sqm[2]);
      sres[0] <= '0;
      de[0]    <= se[RB];
      droot[0] <= sres[RB];
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= SB'(se[RB].mag[i]) << tnp_pkg::FRAC_OUT;
        dq[0][i]   <= '0;
      end
      normal_x      <= $signed(nrm[0]);
      normal_y      <= $signed(nrm[1]);
      normal_z      <= $signed(nrm[2]);
      is_degenerate <= de[QB].degen;
      point_inside  <= de[QB].in_tri;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int K = RB - 1 - j;
    logic [SB+1:0] delta;
    assign delta = ((SB+2)'(sres[j]) << (K + 1)) + ((SB+2)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (en) sv[j+1] <= sv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        se[j+1] <= se[j];
        if ((SB+2)'(srem[j]) >= delta) begin
          srem[j+1] <= srem[j] - delta[SB-1:0];
          sres[j+1] <= sres[j] | (RB'(1) << K);
        end else begin
          srem[j+1] <= srem[j];
          sres[j+1] <= sres[j];
        end
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [SB-1:0] trial;
    assign trial = SB'(droot[j]) << K;
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        de[j+1]    <= de[j];
        droot[j+1] <= droot[j];
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= trial) begin
            drem[j+1][i] <= drem[j][i] - trial;
            dq[j+1][i]   <= dq[j][i] | (QB'(1) << K);
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= dq[j][i];
          end
        end
      end
    end
  end

endmodule

>>> verif/tb.sv
// Testbench for triangle_normal_point_inside_core: directed and random words, scoreboard check.
class tri_scoreboard;
  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic               degen, in_tri;
  } tri_result_t;

  tri_result_t                     pending_q[$];
  logic [tnp_pkg::THRESH_BITS-1:0] thr;
  int                              errors;

  function new();
    thr = tnp_pkg::THRESH_RESET;
    errors = 0;
  endfunction

  static function void cross3(input longint u[3], input longint v[3], output longint o[3]);
    o[0] = u[1] * v[2] - u[2] * v[1];
    o[1] = u[2] * v[0] - u[0] * v[2];
    o[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  static function int side_of(input longint p[3], input longint s[3], input longint e[3],
                              input longint n[3]);
    longint             u[3], v[3], c[3];
    logic signed [127:0] acc, cw, nw;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = p[i] - s[i];
      v[i] = e[i] - s[i];
    end
    cross3(u, v, c);
    for (int i = 0; i < 3; i++) begin
      cw = c[i];
      nw = n[i];
      acc += cw * nw;
    end
    return (acc < 0) ? -1 : ((acc != 0) ? 1 : 0);
  endfunction

  static function bit [63:0] floor_sqrt(input bit [63:0] x);
    bit [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > x) one >>= 2;
    while (one != 0) begin
      if (x >= res + one) begin
        x -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  function void note(input logic signed [23:0] w[12]);
    longint      a[3], b[3], c[3], p[3], e1[3], e2[3], n[3];
    bit [63:0]   m[3], big, s2, r, q;
    logic [127:0] sq;
    int          len, s1, s2g, s3;
    tri_result_t x;
    big = 0;
    s2 = 0;
    sq = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = w[i];
      b[i] = w[3+i];
      c[i] = w[6+i];
      p[i] = w[9+i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    cross3(e1, e2, n);
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? -n[i] : n[i];
      sq += {64'd0, m[i]} * {64'd0, m[i]};
      if (m[i] > big) big = m[i];
    end
    x.nx = 0;
    x.ny = 0;
    x.nz = 0;
    x.degen = (sq <= {65'd0, thr});
    x.in_tri = 1'b1;
    if (!x.degen) begin
      while (len < 64 && (big >> len) != 0) len++;
      for (int i = 0; i < 3; i++) begin
        if (len > 31) m[i] >>= (len - 31);
        else m[i] <<= (31 - len);
        s2 += m[i] * m[i];
      end
      r = floor_sqrt(s2);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] << 30) / r;
        if (n[i] < 0) q = -q;
        if (i == 0) x.nx = q[31:0];
        else if (i == 1) x.ny = q[31:0];
        else x.nz = q[31:0];
      end
      s1 = side_of(p, a, b, n);
      s2g = side_of(p, b, c, n);
      s3 = side_of(p, c, a, n);
      x.in_tri = (s1 >= 0 && s2g >= 0 && s3 >= 0) || (s1 <= 0 && s2g <= 0 && s3 <= 0);
    end
    pending_q.push_back(x);
  endfunction

  function void check(input logic signed [31:0] nx, ny, nz, input logic degen, in_tri);
    tri_result_t x;
    if (pending_q.size() == 0) begin
      $error("unexpected result word");
      errors++;
      return;
    end
    x = pending_q.pop_front();
    if (nx !== x.nx) begin $error("normal_x exp %0d got %0d", x.nx, nx); errors++; end
    if (ny !== x.ny) begin $error("normal_y exp %0d got %0d", x.ny, ny); errors++; end
    if (nz !== x.nz) begin $error("normal_z exp %0d got %0d", x.nz, nz); errors++; end
    if (degen !== x.degen) begin
      $error("is_degenerate exp %0d got %0d", x.degen, degen);
      errors++;
    end
    if (in_tri !== x.in_tri) begin
      $error("point_inside exp %0d got %0d", x.in_tri, in_tri);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;
  localparam int     LIMIT = 400000;

  logic                    clk, rst, in_valid, in_stall, cfg_write, out_valid, out_stall;
  logic [tnp_pkg::THRESH_BITS-1:0] cfg_data;
  logic signed [23:0]      crd[12];
  logic signed [31:0]      normal_x, normal_y, normal_z;
  logic                    is_degenerate, point_inside;
  bit                      quiet, hold_req;
  int                      cycles;
  tri_scoreboard           sb;

  triangle_normal_point_inside_core #(.COORD_BITS(24)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .vertex_a_x(crd[0]), .vertex_a_y(crd[1]), .vertex_a_z(crd[2]),
    .vertex_b_x(crd[3]), .vertex_b_y(crd[4]), .vertex_b_z(crd[5]),
    .vertex_c_x(crd[6]), .vertex_c_y(crd[7]), .vertex_c_z(crd[8]),
    .query_x(crd[9]), .query_y(crd[10]), .query_z(crd[11]),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .is_degenerate(is_degenerate), .point_inside(point_inside)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("triangle_normal_point_inside_core: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic signed [23:0] w[12]);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    crd = w;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note(w);
  endtask

  task automatic send_tri(input longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz);
    logic signed [23:0] w[12];
    w = '{24'(ax), 24'(ay), 24'(az), 24'(bx), 24'(by), 24'(bz),
          24'(cx), 24'(cy), 24'(cz), 24'(px), 24'(py), 24'(pz)};
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_thr(input logic [tnp_pkg::THRESH_BITS-1:0] v);
    @(negedge clk);
    cfg_write = 1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 0;
    sb.thr = v;
  endtask

  function automatic longint pick_edge();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  task automatic send_random();
    logic signed [23:0] w[12];
    longint             v[12], wt[3], tot, k;
    int                 r;
    for (int i = 0; i < 12; i++) v[i] = $signed(24'($urandom));
    case ($urandom_range(0, 9))
      3, 4, 5: begin
        for (int i = 0; i < 9; i++) v[i] = longint'($urandom_range(0, 2097152)) - 1048576;
        for (int j = 0; j < 3; j++) wt[j] = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) wt[$urandom_range(0, 2)] = 0;
        tot = wt[0] + wt[1] + wt[2];
        if (tot == 0) begin wt[0] = 1; tot = 1; end
        for (int i = 0; i < 3; i++)
          v[9+i] = (v[i] * wt[0] + v[3+i] * wt[1] + v[6+i] * wt[2]) / tot;
      end
      6: for (int i = 0; i < 12; i++) v[i] = longint'($urandom_range(0, 80)) - 40;
      7: for (int i = 0; i < 12; i++) v[i] = pick_edge();
      8: begin
        for (int i = 0; i < 6; i++) v[i] = longint'($urandom_range(0, 4000)) - 2000;
        k = longint'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) v[6+i] = v[i] + k * (v[3+i] - v[i]);
      end
      9: begin
        r = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
          v[9+i] = v[3*r+i] + longint'($urandom_range(0, 2)) - 1;
      end
      default: ;
    endcase
    for (int i = 0; i < 12; i++) w[i] = 24'(v[i]);
    send_word(w);
  endtask

  task automatic random_phase(input int count, input bit with_hold);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (with_hold && n == count / 2) hold_req = 1;
      send_random();
    end
    quiet = 0;
  endtask

  initial begin
    int nv;
    sb = new();
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    cfg_write = 0;
    cfg_data = 0;
    quiet = 0;
    hold_req = 0;
    cycles = 0;
    for (int i = 0; i < 12; i++) crd[i] = 0;
    fork
      begin
        @(negedge clk);
        while (rst) @(negedge clk);
        forever begin
          if (hold_req) begin
            @(negedge clk);
            out_stall = 1;
            repeat (600) @(negedge clk);
            hold_req = 0;
          end
          nv = quiet ? 0 : $urandom_range(0, 4);
          repeat (nv) begin
            @(negedge clk);
            out_stall = 1;
          end
          @(negedge clk);
          out_stall = 0;
          do @(posedge clk); while (!out_valid);
          sb.check(normal_x, normal_y, normal_z, is_degenerate, point_inside);
        end
      end
    join_none
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(0, 0, 0, CMAX, 0, 0, 0, CMAX, 0, 1, 1, 0);
    send_tri(0, 0, 0, CMAX, 0, 0, 0, CMAX, 0, CMIN, CMIN, CMIN);
    send_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX);
    send_tri(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN);
    send_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 0, 0, 0);
    send_tri(0, 0, 0, 0, CMAX, 0, CMAX, 0, 0, 100, 100, 5);
    send_tri(0, 0, 0, 0, 0, 4096, 0, 4096, 0, 0, 2048, 0);
    send_tri(0, 0, 0, 4096, 0, 0, 0, 0, 4096, 4096, 4096, 4096);
    send_tri(0, 0, 0, 23, 0, 0, 0, 23, 0, 1, 1, 0);
    send_tri(0, 0, 0, 24, 0, 0, 0, 24, 0, 30, 30, 0);
    send_tri(-5, -5, -5, 1000, 2000, 3000, 2000, 4000, 6000, 7, 7, 7);
    send_tri(10, 20, 30, 5000, -7000, 900, -3000, 400, 8000, 10, 20, 30);
    send_tri(0, 0, 0, 8000, 0, 0, 0, 8000, 0, 4000, 4000, 0);
    send_tri(CMAX, 0, CMIN, -1, 1, CMAX, CMIN, CMAX, 0, -1, -1, -1);
    send_tri(123456, -654321, 777, -8000000, 8000000, -3, 5, 6000000, -7000000,
             CMAX, CMIN, 0);
    random_phase(300, 1);
    drain();

    write_thr('0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    send_tri(0, 0, 0, 1, 0, 0, 2, 0, 0, 5, 5, 5);
    random_phase(350, 0);
    drain();

    write_thr(63'h7FFF_FFFF_FFFF_FFFF);
    random_phase(300, 1);
    drain();

    write_thr(63'({$urandom_range(0, 255), $urandom}));
    random_phase(350, 0);
    drain();

    write_thr(63'({$urandom, $urandom} >> 1));
    random_phase(300, 0);
    drain();

    write_thr(tnp_pkg::THRESH_RESET);
    random_phase(300, 1);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("triangle_normal_point_inside_core: match");
    end else begin
      $display("triangle_normal_point_inside_core: mismatch");
    end
    $finish;
  end
endmodule

>>> triangle_normal_point_inside_core.f
hdl/tnp_pkg.sv
hdl/tnp_wmul.sv
hdl/tnp_front.sv
hdl/tnp_fifo.sv
hdl/tnp_back.sv
hdl/triangle_normal_point_inside_core.sv
verif/tb.sv
